/* sv/mrn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrn_pkg: shared types and constants for the mesh ring neighbor block
// Word layouts for queries and answers, grid registers and register indexes.
// ----------------------------------------------------------------------------
package mrn_pkg;

	// Grid and coordinate sizes
	localparam int unsigned DIM_W    = 7;
	localparam int unsigned COORD_W  = 6;
	localparam int unsigned ID_W     = 12;
	localparam int unsigned MAX_DIM  = 64;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

	// Reset values of the grid registers
	localparam logic [DIM_W-1:0] GRID_WIDTH_RST  = 7'd4;
	localparam logic [DIM_W-1:0] GRID_HEIGHT_RST = 7'd4;

	// Direction codes
	localparam logic REQ_PRED = 1'b0;
	localparam logic REQ_SUCC = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [COORD_W-1:0] node_x;
		logic [COORD_W-1:0] node_y;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0] neighbor_id;
		logic            error;
	} rsp_t;

	typedef struct packed {
		logic [DIM_W-1:0] grid_width;
		logic [DIM_W-1:0] grid_height;
	} grid_cfg_t;

endpackage
`default_nettype wire

/* sv/mrn_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrn_cfg: grid size registers
// Holds the configured width and height; written through a plain write port.
// ----------------------------------------------------------------------------
module mrn_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [mrn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mrn_pkg::DIM_W-1:0]     cfg_wdata,
	output mrn_pkg::grid_cfg_t                 grid
);

	logic [mrn_pkg::DIM_W-1:0] width_q;
	logic [mrn_pkg::DIM_W-1:0] height_q;

	// Update the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mrn_pkg::GRID_WIDTH_RST;
			height_q <= mrn_pkg::GRID_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mrn_pkg::REG_GRID_WIDTH:  width_q  <= cfg_wdata;
				mrn_pkg::REG_GRID_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign grid.grid_width  = width_q;
	assign grid.grid_height = height_q;

endmodule
`default_nettype wire

/* sv/mrn_ring.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrn_ring: ring neighbor logic
// Picks the neighbor coordinate by grid shape, then forms row * width + col.
// ----------------------------------------------------------------------------
module mrn_ring (
	input  wire mrn_pkg::req_t      req,
	input  wire mrn_pkg::grid_cfg_t grid,
	output mrn_pkg::rsp_t           rsp
);

	localparam int unsigned CW = mrn_pkg::COORD_W;
	localparam int unsigned DW = mrn_pkg::DIM_W;
	localparam int unsigned PW = CW + DW;

	logic [CW-1:0] x, y, nx, ny;
	logic [DW-1:0] w, h, wm1, hm1;
	logic          right;
	logic          x0, x1, xgt1, xl, y0, y1, yl, ev_x, ev_y;
	logic          bad;
	logic [PW-1:0] row_base;
	logic [PW-1:0] lin;

	assign x     = req.node_x;
	assign y     = req.node_y;
	assign right = (req.req_type == mrn_pkg::REQ_SUCC);
	assign w     = grid.grid_width;
	assign h     = grid.grid_height;
	assign wm1   = w - DW'(1);
	assign hm1   = h - DW'(1);

	// Position flags
	assign x0   = (x == '0);
	assign x1   = (x == CW'(1));
	assign xgt1 = (x > CW'(1));
	assign xl   = ({1'b0, x} == wm1);
	assign y0   = (y == '0);
	assign y1   = (y == CW'(1));
	assign yl   = ({1'b0, y} == hm1);
	assign ev_x = ~x[0];
	assign ev_y = ~y[0];

	// Refuse single-node grids, oversize grids and coordinates off the grid
	assign bad = ((w <= DW'(1)) && (h <= DW'(1))) ||
		(w > DW'(mrn_pkg::MAX_DIM)) || (h > DW'(mrn_pkg::MAX_DIM)) ||
		({1'b0, x} >= w) || ({1'b0, y} >= h);

	// Select the neighbor coordinate
	always_comb begin
		nx = x;
		ny = y;
		priority if (w == DW'(1)) begin
			// single column: walk the rows and wrap
			nx = '0;
			if (right) ny = yl ? '0 : y + CW'(1);
			else       ny = y0 ? CW'(hm1) : y - CW'(1);
		end else if (h == DW'(1)) begin
			// single row: walk the columns and wrap
			ny = '0;
			if (right) nx = xl ? '0 : x + CW'(1);
			else       nx = x0 ? CW'(wm1) : x - CW'(1);
		end else if (h == DW'(2)) begin
			// two rows: out along row zero, back along row one
			if (right) begin
				if (y0) begin
					if (xl) ny = CW'(1); else nx = x + CW'(1);
				end else begin
					if (x0) ny = '0; else nx = x - CW'(1);
				end
			end else begin
				if (y0) begin
					if (x0) ny = CW'(1); else nx = x - CW'(1);
				end else begin
					if (xl) ny = '0; else nx = x + CW'(1);
				end
			end
		end else if (w == DW'(2)) begin
			// two columns: down column zero, up column one
			if (right) begin
				if (x0) begin
					if (yl) nx = CW'(1); else ny = y + CW'(1);
				end else begin
					if (y0) nx = '0; else ny = y - CW'(1);
				end
			end else begin
				if (x0) begin
					if (y0) nx = CW'(1); else ny = y - CW'(1);
				end else begin
					if (yl) nx = '0; else ny = y + CW'(1);
				end
			end
		end else if (!w[0]) begin
			// even width: row zero across, snake up and down the columns
			if (right) begin
				priority if (y0) begin
					if (xl) ny = CW'(1); else nx = x + CW'(1);
				end else if (y1) begin
					priority if (x0)     ny = '0;
					else if (xl)         ny = CW'(2);
					else if (ev_x)       nx = x - CW'(1);
					else                 ny = CW'(2);
				end else if (yl) begin
					if (ev_x) ny = y - CW'(1); else nx = x - CW'(1);
				end else begin
					if (ev_x) ny = y - CW'(1); else ny = y + CW'(1);
				end
			end else begin
				priority if (y0) begin
					if (x0) ny = CW'(1); else nx = x - CW'(1);
				end else if (y1) begin
					priority if (x0)     ny = CW'(2);
					else if (xl)         ny = '0;
					else if (ev_x)       ny = CW'(2);
					else                 nx = x + CW'(1);
				end else if (yl) begin
					if (ev_x) nx = x + CW'(1); else ny = y - CW'(1);
				end else begin
					if (ev_x) ny = y + CW'(1); else ny = y - CW'(1);
				end
			end
		end else if (!h[0]) begin
			// odd width, even height: column zero up, snake along the rows
			if (right) begin
				priority if (x0) begin
					if (y0) nx = CW'(1); else ny = y - CW'(1);
				end else if (x1) begin
					priority if (y0)     nx = CW'(2);
					else if (yl)         nx = '0;
					else if (ev_y)       nx = CW'(2);
					else                 ny = y + CW'(1);
				end else if (xl) begin
					if (ev_y) ny = y + CW'(1); else nx = x - CW'(1);
				end else begin
					if (ev_y) nx = x + CW'(1); else nx = x - CW'(1);
				end
			end else begin
				priority if (x0) begin
					if (yl) nx = CW'(1); else ny = y + CW'(1);
				end else if (x1) begin
					priority if (y0)     nx = '0;
					else if (yl)         nx = CW'(2);
					else if (ev_y)       ny = y - CW'(1);
					else                 nx = CW'(2);
				end else if (xl) begin
					if (ev_y) nx = x - CW'(1); else ny = y - CW'(1);
				end else begin
					if (ev_y) nx = x - CW'(1); else nx = x + CW'(1);
				end
			end
		end else begin
			// both odd: close the ring with the diagonal between (1,1) and (0,0)
			if (right) begin
				priority if (y0) begin
					if (xl) ny = CW'(1); else nx = x + CW'(1);
				end else if (xgt1) begin
					priority if (y1) begin
						if (xl || ev_x) ny = CW'(2); else nx = x - CW'(1);
					end else if (yl) begin
						if (ev_x) nx = x - CW'(1); else ny = y - CW'(1);
					end else begin
						if (ev_x) ny = y + CW'(1); else ny = y - CW'(1);
					end
				end else if (x1 && y1) begin
					nx = '0;
					ny = '0;
				end else if (x1 && yl) begin
					nx = '0;
				end else if (x0) begin
					if (ev_y) ny = y - CW'(1); else nx = CW'(1);
				end else begin
					if (ev_y) nx = '0; else ny = y - CW'(1);
				end
			end else begin
				priority if (y0) begin
					if (x0) begin
						nx = CW'(1);
						ny = CW'(1);
					end else begin
						nx = x - CW'(1);
					end
				end else if (xgt1) begin
					priority if (y1) begin
						priority if (xl) ny = '0;
						else if (ev_x)   nx = x + CW'(1);
						else             ny = CW'(2);
					end else if (yl) begin
						if (ev_x) ny = y - CW'(1); else nx = x + CW'(1);
					end else begin
						if (ev_x) ny = y - CW'(1); else ny = y + CW'(1);
					end
				end else if (x1 && y1) begin
					nx = '0;
				end else if (x1 && yl) begin
					nx = CW'(2);
				end else if (x0) begin
					if (ev_y) nx = CW'(1); else ny = y + CW'(1);
				end else begin
					if (ev_y) ny = y + CW'(1); else nx = '0;
				end
			end
		end
	end

	// Linear id: row times width plus column
	assign row_base = PW'(ny) * PW'(w);
	assign lin      = row_base + PW'(nx);

	assign rsp.neighbor_id = bad ? '0 : lin[mrn_pkg::ID_W-1:0];
	assign rsp.error       = bad;

endmodule
`default_nettype wire

/* sv/mesh_ring_neighbor.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mesh_ring_neighbor: neighbor of a node on a ring over a processor mesh
// Input register, ring neighbor logic, result register.
// ----------------------------------------------------------------------------
// Takes one query word per cycle while the output side is not stalled: the
// query lands in an input register, the ring case selection and the
// row-times-width multiply run in one pass, and the answer sits in a result
// register until taken. Throughput is one word per clock when not stalled,
// set by that single pass between the two registers.
// The grid width and height registers (index 0 and 1) reset to 4 by 4 and
// should be written only while no query is in flight. A single-node grid, a
// dimension over 64 or a coordinate off the grid answers with error set and
// a zero id.
module mesh_ring_neighbor (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [mrn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mrn_pkg::DIM_W-1:0]     cfg_wdata,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire mrn_pkg::req_t                 req,
	output logic                               rsp_valid,
	input  wire logic                          rsp_ready,
	output mrn_pkg::rsp_t                      rsp
);

	mrn_pkg::grid_cfg_t grid;
	mrn_pkg::req_t      req_s1;
	mrn_pkg::rsp_t      rsp_c;
	mrn_pkg::rsp_t      rsp_s2;
	logic               valid_s1;
	logic               valid_s2;
	logic               free_s2;
	logic               adv_s1;

	mrn_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.grid      (grid)
	);

	mrn_ring u_ring (
		.req  (req_s1),
		.grid (grid),
		.rsp  (rsp_c)
	);

	// Stage flow control
	assign free_s2   = !valid_s2 || rsp_ready;
	assign adv_s1    = valid_s1 && free_s2;
	assign req_ready = !valid_s1 || free_s2;

	// Hold the query word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	// Hold the answer word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_s2 <= rsp_c;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	// A refused query never carries an id
	a_err_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.error |-> rsp_s2.neighbor_id == '0)
		else $error("error answer with nonzero id");

	// Both stages full and output stalled: no new word may enter
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !rsp_ready |-> !req_ready)
		else $error("query taken while pipeline full");

	// A word that leaves the input register shows up as an answer next cycle
	a_adv_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> valid_s2)
		else $error("advanced word lost");

	// The answer register holds the logic result of the word that advanced
	a_adv_value: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> rsp_s2 == $past(rsp_c))
		else $error("answer does not match advanced word");

endmodule
`default_nettype wire

/* sim/mrn_ring_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrn_ring_checker: answer checker for the mesh ring neighbor block
// Tracks grid register writes, works out the ring neighbor of every accepted
// query word and compares each answer word against the oldest one due.
// ----------------------------------------------------------------------------
module mrn_ring_checker
	import mrn_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_wdata,
	input  wire logic                 req_valid,
	input  wire logic                 req_ready,
	input  req_t                      req,
	input  wire logic                 rsp_valid,
	input  wire logic                 rsp_ready,
	input  rsp_t                      rsp,
	output int                        mismatch_count,
	output int                        answers_pending,
	output int                        answers_checked,
	output int                        refusals_seen
);

	logic [DIM_W-1:0] grid_w = GRID_WIDTH_RST;
	logic [DIM_W-1:0] grid_h = GRID_HEIGHT_RST;
	rsp_t             neighbor_due[$];

	// Step along a ring that runs out on line 0 and back on line 1
	function automatic void two_line_step(input int unsigned a, b, len, input bit right,
			output int unsigned na, nb);
		na = a;
		nb = b;
		if (right) begin
			if (a == 0) begin
				if (b == len - 1) na = 1;
				else nb = b + 1;
			end else begin
				if (b == 0) na = 0;
				else nb = b - 1;
			end
		end else begin
			if (a == 0) begin
				if (b == 0) na = 1;
				else nb = b - 1;
			end else begin
				if (b == len - 1) na = 0;
				else nb = b + 1;
			end
		end
	endfunction

	// Work out the answer word for one query on a w by h grid
	function automatic rsp_t ring_neighbor_of(input req_t q, input int unsigned w, h);
		int unsigned x, y, nx, ny;
		bit          right, ev;
		rsp_t        a;
		x = q.node_x;
		y = q.node_y;
		right = (q.req_type == REQ_SUCC);
		a.neighbor_id = '0;
		a.error = 1'b0;
		if ((w <= 1 && h <= 1) || w > MAX_DIM || h > MAX_DIM || x >= w || y >= h) begin
			a.error = 1'b1;
			return a;
		end
		nx = x;
		ny = y;
		if (w == 1) begin
			if (right) ny = (y == h - 1) ? 0 : y + 1;
			else ny = (y == 0) ? h - 1 : y - 1;
		end else if (h == 1) begin
			if (right) nx = (x == w - 1) ? 0 : x + 1;
			else nx = (x == 0) ? w - 1 : x - 1;
		end else if (h == 2) begin
			two_line_step(y, x, w, right, ny, nx);
		end else if (w == 2) begin
			two_line_step(x, y, h, right, nx, ny);
		end else if (w % 2 == 0) begin
			// even width: columns snake between row 1 and the bottom row
			ev = (x % 2 == 0);
			if (right) begin
				if (y == 0) begin
					if (x == w - 1) ny = 1;
					else nx = x + 1;
				end else if (y == 1) begin
					if (x == 0) ny = 0;
					else if (x == w - 1) ny = 2;
					else if (ev) nx = x - 1;
					else ny = 2;
				end else if (y == h - 1) begin
					if (ev) ny = y - 1;
					else nx = x - 1;
				end else begin
					if (ev) ny = y - 1;
					else ny = y + 1;
				end
			end else begin
				if (y == 0) begin
					if (x == 0) ny = 1;
					else nx = x - 1;
				end else if (y == 1) begin
					if (x == 0) ny = 2;
					else if (x == w - 1) ny = 0;
					else if (ev) ny = 2;
					else nx = x + 1;
				end else if (y == h - 1) begin
					if (ev) nx = x + 1;
					else ny = y - 1;
				end else begin
					if (ev) ny = y + 1;
					else ny = y - 1;
				end
			end
		end else if (h % 2 == 0) begin
			// odd width, even height: rows snake between column 1 and the last column
			ev = (y % 2 == 0);
			if (right) begin
				if (x == 0) begin
					if (y == 0) nx = 1;
					else ny = y - 1;
				end else if (x == 1) begin
					if (y == 0) nx = 2;
					else if (y == h - 1) nx = 0;
					else if (ev) nx = 2;
					else ny = y + 1;
				end else if (x == w - 1) begin
					if (ev) ny = y + 1;
					else nx = x - 1;
				end else begin
					if (ev) nx = x + 1;
					else nx = x - 1;
				end
			end else begin
				if (x == 0) begin
					if (y == h - 1) nx = 1;
					else ny = y + 1;
				end else if (x == 1) begin
					if (y == 0) nx = 0;
					else if (y == h - 1) nx = 2;
					else if (ev) ny = y - 1;
					else nx = 2;
				end else if (x == w - 1) begin
					if (ev) nx = x - 1;
					else ny = y - 1;
				end else begin
					if (ev) nx = x - 1;
					else nx = x + 1;
				end
			end
		end else begin
			// both odd: ring closes through the diagonal between (1,1) and (0,0)
			if (right) begin
				if (y == 0) begin
					if (x == w - 1) ny = 1;
					else nx = x + 1;
				end else if (x > 1) begin
					ev = (x % 2 == 0);
					if (y == 1) begin
						if (x == w - 1 || ev) ny = 2;
						else nx = x - 1;
					end else if (y == h - 1) begin
						if (ev) nx = x - 1;
						else ny = y - 1;
					end else begin
						if (ev) ny = y + 1;
						else ny = y - 1;
					end
				end else if (x == 1 && y == 1) begin
					nx = 0;
					ny = 0;
				end else if (x == 1 && y == h - 1) begin
					nx = 0;
				end else begin
					ev = (y % 2 == 0);
					if (x == 0) begin
						if (ev) ny = y - 1;
						else nx = 1;
					end else begin
						if (ev) nx = 0;
						else ny = y - 1;
					end
				end
			end else begin
				if (y == 0) begin
					if (x == 0) begin
						nx = 1;
						ny = 1;
					end else begin
						nx = x - 1;
					end
				end else if (x > 1) begin
					ev = (x % 2 == 0);
					if (y == 1) begin
						if (x == w - 1) ny = 0;
						else if (ev) nx = x + 1;
						else ny = 2;
					end else if (y == h - 1) begin
						if (ev) ny = y - 1;
						else nx = x + 1;
					end else begin
						if (ev) ny = y - 1;
						else ny = y + 1;
					end
				end else if (x == 1 && y == 1) begin
					nx = 0;
				end else if (x == 1 && y == h - 1) begin
					nx = 2;
				end else begin
					ev = (y % 2 == 0);
					if (x == 0) begin
						if (ev) nx = 1;
						else ny = y + 1;
					end else begin
						if (ev) ny = y + 1;
						else nx = 0;
					end
				end
			end
		end
		a.neighbor_id = ID_W'(ny * w + nx);
		return a;
	endfunction

	// Follow register writes, queue answers for queries, match answer words
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			grid_w = GRID_WIDTH_RST;
			grid_h = GRID_HEIGHT_RST;
			neighbor_due.delete();
			mismatch_count <= 0;
			answers_pending <= 0;
			answers_checked <= 0;
			refusals_seen <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_GRID_WIDTH) grid_w = cfg_wdata;
				else if (cfg_index == REG_GRID_HEIGHT) grid_h = cfg_wdata;
			end
			if (rsp_valid && rsp_ready) begin
				if (neighbor_due.size() == 0) begin
					$display("%0t: answer word id %0d error %0d with no query pending",
						$time, rsp.neighbor_id, rsp.error);
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = neighbor_due.pop_front();
					if (want.neighbor_id !== rsp.neighbor_id || want.error !== rsp.error) begin
						if (want.neighbor_id !== rsp.neighbor_id)
							$display("%0t: neighbor_id expected %0d, got %0d",
								$time, want.neighbor_id, rsp.neighbor_id);
						if (want.error !== rsp.error)
							$display("%0t: error expected %0d, got %0d",
								$time, want.error, rsp.error);
						mismatch_count <= mismatch_count + 1;
					end
					if (want.error) refusals_seen <= refusals_seen + 1;
					answers_checked <= answers_checked + 1;
				end
			end
			if (req_valid && req_ready)
				neighbor_due.push_back(ring_neighbor_of(req, grid_w, grid_h));
			answers_pending <= neighbor_due.size();
		end
	end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: mesh ring neighbor testbench
// Sets grid shapes between bursts of neighbor queries, randomizes idling on
// both channels and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb;
	import mrn_pkg::*;

	localparam int PHASES = 48;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_GRID_WIDTH;
	logic [DIM_W-1:0]     cfg_wdata = '0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	req_t                 req = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	rsp_t                 rsp;

	int mismatch_count, answers_pending, answers_checked, refusals_seen;
	int send_idle_pct = 6;
	int recv_stall_pct = 60;
	int queries_sent = 0;
	int grid_settings = 1;

	mesh_ring_neighbor DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	mrn_ring_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.req             (req),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.rsp             (rsp),
		.mismatch_count  (mismatch_count),
		.answers_pending (answers_pending),
		.answers_checked (answers_checked),
		.refusals_seen   (refusals_seen)
	);

	always #6 clk = ~clk;

	// Stall the answer side at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_ready <= 1'b0;
		else rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Pick the idling split: sender light, receiver light, or none
	task automatic set_idling(input int mode);
		case (mode)
			0: begin
				send_idle_pct = 6;
				recv_stall_pct <= 60;
			end
			1: begin
				send_idle_pct = 60;
				recv_stall_pct <= 6;
			end
			default: begin
				send_idle_pct = 0;
				recv_stall_pct <= 0;
			end
		endcase
	endtask

	// Write both grid registers on back-to-back cycles
	task automatic set_grid(input int unsigned w, h);
		cfg_we <= 1'b1;
		cfg_index <= REG_GRID_WIDTH;
		cfg_wdata <= DIM_W'(w);
		@(posedge clk);
		cfg_index <= REG_GRID_HEIGHT;
		cfg_wdata <= DIM_W'(h);
		@(posedge clk);
		cfg_we <= 1'b0;
		grid_settings++;
	endtask

	// Offer one query word, idling first if the dice say so
	task automatic ask(input logic dir, input int unsigned x, y);
		req_t        q;
		int unsigned gap;
		q.req_type = dir;
		q.node_x = COORD_W'(x);
		q.node_y = COORD_W'(y);
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct) gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= q;
		do @(posedge clk); while (!req_ready);
		queries_sent++;
	endtask

	// Drop valid and hold until every answer is back, then settle
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (answers_pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// Mostly on the grid and near its borders, sometimes anywhere
	function automatic int unsigned pick_coord(input int unsigned dim);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (dim == 0 || dim > MAX_DIM || r == 0) return $urandom_range(0, 63);
		case (r)
			1: return 0;
			2: return dim - 1;
			3: return (dim > 1) ? 1 : 0;
			4: return (dim > 1) ? dim - 2 : 0;
			default: return $urandom_range(0, dim - 1);
		endcase
	endfunction

	initial begin
		int unsigned rim_dims[5] = '{1, 2, 3, 63, 64};
		int unsigned w, h, n;

		set_idling(0);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset shape 4 by 4, corners and off-grid coordinates
		ask(REQ_SUCC, 0, 0);
		ask(REQ_PRED, 0, 0);
		ask(REQ_SUCC, 3, 3);
		ask(REQ_PRED, 3, 3);
		ask(REQ_SUCC, 4, 0);
		ask(REQ_PRED, 63, 63);
		drain();
		// Largest grid and the highest id
		set_grid(64, 64);
		ask(REQ_SUCC, 63, 63);
		ask(REQ_PRED, 63, 63);
		ask(REQ_SUCC, 0, 0);
		ask(REQ_PRED, 63, 0);
		drain();
		// Single node, zero width, oversize width: all refused
		set_grid(1, 1);
		ask(REQ_SUCC, 0, 0);
		drain();
		set_grid(0, 5);
		ask(REQ_PRED, 0, 0);
		drain();
		set_grid(127, 3);
		ask(REQ_SUCC, 0, 0);
		drain();
		// Two by two takes the two-row form, then a two-column grid
		set_grid(2, 2);
		ask(REQ_SUCC, 0, 0);
		ask(REQ_PRED, 1, 1);
		drain();
		set_grid(2, 5);
		ask(REQ_SUCC, 1, 0);
		ask(REQ_PRED, 0, 4);
		drain();
		// Odd by odd around the diagonal link
		set_grid(3, 3);
		ask(REQ_SUCC, 1, 1);
		ask(REQ_PRED, 0, 0);
		drain();
		// Single column and single row wrap-around
		set_grid(1, 6);
		ask(REQ_SUCC, 0, 5);
		ask(REQ_PRED, 0, 0);
		drain();
		set_grid(6, 1);
		ask(REQ_SUCC, 5, 0);
		ask(REQ_PRED, 0, 0);
		drain();

		// Random bursts, each on its own grid shape
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase % (PHASES / 3) == 0) set_idling(phase / (PHASES / 3));
			case ($urandom_range(0, 11))
				0: begin
					w = 1;
					h = $urandom_range(2, 64);
				end
				1: begin
					w = $urandom_range(2, 64);
					h = 1;
				end
				2: begin
					w = $urandom_range(2, 64);
					h = 2;
				end
				3: begin
					w = 2;
					h = $urandom_range(3, 64);
				end
				4: begin
					w = 2 * $urandom_range(1, 31) + 1;
					h = 2 * $urandom_range(1, 31) + 1;
				end
				5: begin
					w = 2 * $urandom_range(2, 32);
					h = $urandom_range(3, 64);
				end
				6: begin
					w = 2 * $urandom_range(1, 31) + 1;
					h = 2 * $urandom_range(2, 32);
				end
				7: begin
					w = rim_dims[$urandom_range(0, 4)];
					h = rim_dims[$urandom_range(0, 4)];
				end
				8: begin
					w = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
					h = $urandom_range(1, 64);
					if ($urandom_range(0, 1)) begin
						n = w;
						w = h;
						h = n;
					end
				end
				9: begin
					w = 3;
					h = 3;
				end
				default: begin
					w = $urandom_range(1, 64);
					h = $urandom_range(1, 64);
				end
			endcase
			set_grid(w, h);
			n = $urandom_range(25, 41);
			repeat (n) ask($urandom_range(0, 1) ? REQ_SUCC : REQ_PRED,
				pick_coord(w), pick_coord(h));
			drain();
		end

		$display("%0d queries over %0d grid shapes, %0d answers compared (%0d refused)",
			queries_sent, grid_settings, answers_checked, refusals_seen);
		if (mismatch_count == 0 && answers_pending == 0) begin
			$display("mesh_ring_neighbor verification clean");
		end else begin
			$display("mesh_ring_neighbor verification failed");
		end
		$finish;
	end

	// Hang guard
	initial begin
		#2_000_000;
		$display("mesh_ring_neighbor verification failed");
		$finish;
	end

endmodule

/* mesh_ring_neighbor.f */
sv/mrn_pkg.sv
sv/mrn_cfg.sv
sv/mrn_ring.sv
sv/mesh_ring_neighbor.sv
sim/mrn_ring_checker.sv
sim/tb.sv
